/* sv/sst_pkg.sv */
// Shared types and constants for the sorted sequence table.
`default_nettype none

package sst_pkg;

    localparam int DEPTH    = 32;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // Operation codes carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRIM_LO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRIM_HI = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    // Stream widths
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 192;
    localparam int M_TUSER_W = STATUS_W + 1;
    localparam int M_PAD_W   = M_TDATA_W - (3 * HANDLE_W + 2 * CNT_W + 2 * KEY_W);

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR,
        CELL_DROP_LAST
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } cell_ctrl_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } cell_data_t;

    typedef struct packed {
        logic ins;    // new key belongs here or further left
        logic eq;
        logic below;  // held key less than operand
        logic above;  // held key greater than operand
        logic last;   // highest valid cell
    } cell_flags_t;

endpackage

`default_nettype wire

/* sv/sst_cell.sv */
// One table cell: holds an entry, compares it with the operand, trades with its neighbors.
`default_nettype none

module sst_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sst_pkg::cell_ctrl_t ctrl,
    input  sst_pkg::cell_data_t prev_data,
    input  wire                 prev_ins,
    input  sst_pkg::cell_data_t next_data,
    output sst_pkg::cell_data_t cell_data,
    output sst_pkg::cell_flags_t flags
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [sst_pkg::KEY_W-1:0]    key_reg;
    logic [sst_pkg::KEY_W-1:0]    key_next;
    logic [sst_pkg::HANDLE_W-1:0] handle_reg;
    logic [sst_pkg::HANDLE_W-1:0] handle_next;

    always_comb begin
        flags.eq    = valid_reg && (key_reg == ctrl.key);
        flags.below = valid_reg && (key_reg < ctrl.key);
        flags.above = valid_reg && (ctrl.key < key_reg);
        flags.ins   = !valid_reg || (ctrl.key < key_reg);
        flags.last  = valid_reg && !next_data.valid;
    end

    always_comb begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        case (ctrl.op)
            sst_pkg::CELL_INSERT: begin
                if (flags.ins) begin
                    // take the left neighbor when the gap opens further left
                    if (prev_ins) begin
                        valid_next  = prev_data.valid;
                        key_next    = prev_data.key;
                        handle_next = prev_data.handle;
                    end else begin
                        valid_next  = 1'b1;
                        key_next    = ctrl.key;
                        handle_next = ctrl.handle;
                    end
                end
            end
            sst_pkg::CELL_SHIFT: begin
                valid_next  = next_data.valid;
                key_next    = next_data.key;
                handle_next = next_data.handle;
            end
            sst_pkg::CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            sst_pkg::CELL_DROP_LAST: begin
                if (flags.last) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign cell_data.valid  = valid_reg;
    assign cell_data.key    = key_reg;
    assign cell_data.handle = handle_reg;

endmodule

`default_nettype wire

/* sv/sorted_sequence_table.sv */
// Sorted sequence table: a row of key cells kept in ascending order, with its sequencer.
//
//  channel | direction | tdata                           | tuser
//  s_      | in        | key, handle, handle_ok          | mode
//  m_      | out       | found_handle .. last_handle     | status, found
//
// Insert, lookup, clear and unused modes go from accept straight to the load of the output
// register. Trims run a trim state between the two, in which the row shifts left or drops
// its last cell one entry per cycle. A new transaction is accepted while a result waits
// in the output register; the next result waits for that register to free up.
// Reset empties the table at once; no clearing pass.
`default_nettype none

module sorted_sequence_table (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [63:0] key, [79:64] handle, [80] handle_ok, [87:81] zero
    input  wire  [sst_pkg::S_TDATA_W-1:0]    s_tdata,
    // [2:0] mode
    input  wire  [sst_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [15:0] found_handle, [21:16] removed_count, [27:22] entry_count, [91:28] first_key,
    // [155:92] last_key, [171:156] first_handle, [187:172] last_handle, [191:188] zero
    output logic [sst_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status, [2] found
    output logic [sst_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int D = sst_pkg::DEPTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM_LO,
        ST_TRIM_HI,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [sst_pkg::CNT_W-1:0]      occ_reg;
    logic [sst_pkg::CNT_W-1:0]      removed_reg;
    logic [sst_pkg::STATUS_W-1:0]   status_reg;
    logic                           found_reg;
    logic [sst_pkg::HANDLE_W-1:0]   fhandle_reg;
    logic [sst_pkg::KEY_W-1:0]      bound_reg;
    logic                           m_tvalid_reg;
    logic [sst_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [sst_pkg::M_TUSER_W-1:0]  m_tuser_reg;

    logic [sst_pkg::MODE_W-1:0]     in_mode;
    logic [sst_pkg::KEY_W-1:0]      in_key;
    logic [sst_pkg::HANDLE_W-1:0]   in_handle;
    logic                           in_handle_ok;
    logic                           in_fire;
    logic                           out_free;

    sst_pkg::cell_ctrl_t            ctrl;
    sst_pkg::cell_data_t            cdata [D];
    sst_pkg::cell_flags_t           cflags [D];
    logic [D-1:0]                   valid_vec;

    logic                           dup;
    logic                           full;
    logic [sst_pkg::STATUS_W-1:0]   ins_status;
    logic [sst_pkg::HANDLE_W-1:0]   match_handle;
    logic [sst_pkg::KEY_W-1:0]      last_key;
    logic [sst_pkg::HANDLE_W-1:0]   last_handle;
    logic                           last_above;
    logic [sst_pkg::KEY_W-1:0]      first_key;
    logic [sst_pkg::HANDLE_W-1:0]   first_handle;

    assign in_mode      = s_tuser[sst_pkg::MODE_W-1:0];
    assign in_key       = s_tdata[63:0];
    assign in_handle    = s_tdata[79:64];
    assign in_handle_ok = s_tdata[80];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---- cell row ----
    for (genvar i = 0; i < D; i++) begin : g_cell
        sst_pkg::cell_data_t prev_d;
        sst_pkg::cell_data_t next_d;
        logic                prev_i;
        if (i == 0) begin : g_head
            assign prev_d = '{valid: 1'b1, key: '0, handle: '0};
            assign prev_i = 1'b0;
        end else begin : g_body
            assign prev_d = cdata[i-1];
            assign prev_i = cflags[i-1].ins;
        end
        if (i == D - 1) begin : g_tail
            assign next_d = '{valid: 1'b0, key: '0, handle: '0};
        end else begin : g_mid
            assign next_d = cdata[i+1];
        end
        sst_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .prev_ins  (prev_i),
            .next_data (next_d),
            .cell_data (cdata[i]),
            .flags     (cflags[i])
        );
        assign valid_vec[i] = cdata[i].valid;
    end

    // ---- row-wide reductions ----
    always_comb begin
        dup          = 1'b0;
        match_handle = '0;
        last_key     = '0;
        last_handle  = '0;
        last_above   = 1'b0;
        for (int i = 0; i < D; i++) begin
            dup          = dup | cflags[i].eq;
            match_handle = match_handle | ({sst_pkg::HANDLE_W{cflags[i].eq}} & cdata[i].handle);
            last_key     = last_key | ({sst_pkg::KEY_W{cflags[i].last}} & cdata[i].key);
            last_handle  = last_handle
                         | ({sst_pkg::HANDLE_W{cflags[i].last}} & cdata[i].handle);
            last_above   = last_above | (cflags[i].last & cflags[i].above);
        end
    end

    assign first_key    = cdata[0].valid ? cdata[0].key : '0;
    assign first_handle = cdata[0].valid ? cdata[0].handle : '0;
    assign full         = (occ_reg == sst_pkg::CNT_W'(D));

    always_comb begin
        if (!in_handle_ok) begin
            ins_status = sst_pkg::STATUS_INVALID;
        end else if (dup) begin
            ins_status = sst_pkg::STATUS_DUP;
        end else if (full) begin
            ins_status = sst_pkg::STATUS_FULL;
        end else begin
            ins_status = sst_pkg::STATUS_OK;
        end
    end

    // ---- cell command ----
    always_comb begin
        ctrl.op     = sst_pkg::CELL_HOLD;
        ctrl.key    = (state_reg == ST_IDLE) ? in_key : bound_reg;
        ctrl.handle = in_handle;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_mode == sst_pkg::MODE_INSERT && ins_status == sst_pkg::STATUS_OK) begin
                        ctrl.op = sst_pkg::CELL_INSERT;
                    end else if (in_mode == sst_pkg::MODE_CLEAR) begin
                        ctrl.op = sst_pkg::CELL_CLEAR;
                    end
                end
            end
            ST_TRIM_LO: begin
                if (cflags[0].below) begin
                    ctrl.op = sst_pkg::CELL_SHIFT;
                end
            end
            ST_TRIM_HI: begin
                if (last_above) begin
                    ctrl.op = sst_pkg::CELL_DROP_LAST;
                end
            end
            default: begin
                ctrl.op = sst_pkg::CELL_HOLD;
            end
        endcase
    end

    // ---- sequencer and output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        bound_reg   <= in_key;
                        status_reg  <= (in_mode == sst_pkg::MODE_INSERT) ? ins_status
                                                                           : sst_pkg::STATUS_OK;
                        found_reg   <= (in_mode == sst_pkg::MODE_LOOKUP) && dup;
                        fhandle_reg <= (in_mode == sst_pkg::MODE_LOOKUP) ? match_handle : '0;
                        removed_reg <= (in_mode == sst_pkg::MODE_CLEAR) ? occ_reg : '0;
                        case (in_mode)
                            sst_pkg::MODE_INSERT: begin
                                state_reg <= ST_FINISH;
                                if (ins_status == sst_pkg::STATUS_OK) begin
                                    occ_reg <= occ_reg + 1'b1;
                                end
                            end
                            sst_pkg::MODE_TRIM_LO: begin
                                state_reg <= ST_TRIM_LO;
                            end
                            sst_pkg::MODE_TRIM_HI: begin
                                state_reg <= ST_TRIM_HI;
                            end
                            sst_pkg::MODE_CLEAR: begin
                                occ_reg   <= '0;
                                state_reg <= ST_FINISH;
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_TRIM_LO: begin
                    if (cflags[0].below) begin
                        occ_reg     <= occ_reg - 1'b1;
                        removed_reg <= removed_reg + 1'b1;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_TRIM_HI: begin
                    if (last_above) begin
                        occ_reg     <= occ_reg - 1'b1;
                        removed_reg <= removed_reg + 1'b1;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        m_tdata_reg  <= {{sst_pkg::M_PAD_W{1'b0}}, last_handle, first_handle,
                                         last_key, first_key, occ_reg, removed_reg,
                                         fhandle_reg};
                        m_tuser_reg  <= {found_reg, status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---- assertions ----
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy disagrees with valid cells");

    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("valid cells not packed from the head");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == sst_pkg::CELL_INSERT) |-> !full)
        else $error("insert issued into a full table");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && state_reg == ST_FINISH) |=> (state_reg == ST_FINISH))
        else $error("result dropped while output register busy");

endmodule

`default_nettype wire

/* bench/sorted_sequence_table_tb.sv */
// Self-checking bench for the sorted sequence table: directed table, then random operations.
module sorted_sequence_table_tb;

    localparam logic [sst_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [sst_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [sst_pkg::KEY_W-1:0]  KEY_TOP  = '1;
    localparam logic [sst_pkg::KEY_W-1:0]  RUN_BASE = 64'h8000_0000_0000_0000;
    localparam int RANDOM_OPS   = 1825;
    localparam int DRAIN_CYCLES = 2 * sst_pkg::DEPTH + 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int N_ROWS       = 25;

    typedef struct packed {
        logic [sst_pkg::STATUS_W-1:0] status;
        logic                         found;
        logic [sst_pkg::HANDLE_W-1:0] found_handle;
        logic [sst_pkg::CNT_W-1:0]    removed;
        logic [sst_pkg::CNT_W-1:0]    count;
        logic [sst_pkg::KEY_W-1:0]    first_key;
        logic [sst_pkg::KEY_W-1:0]    last_key;
        logic [sst_pkg::HANDLE_W-1:0] first_handle;
        logic [sst_pkg::HANDLE_W-1:0] last_handle;
    } tbl_result_t;

    typedef struct packed {
        logic [sst_pkg::KEY_W-1:0]    key;
        logic [sst_pkg::HANDLE_W-1:0] hnd;
    } held_entry_t;

    typedef struct packed {
        logic [sst_pkg::MODE_W-1:0]   mode;
        logic [sst_pkg::KEY_W-1:0]    key;
        logic [sst_pkg::HANDLE_W-1:0] hnd;
        logic                         ok;
        logic [5:0]                   reps;   // key and handle advance by one per repeat
        logic                         typed;  // want holds the result to expect
        tbl_result_t                  want;
    } dir_row_t;

    localparam tbl_result_t EMPTY_RESULT = '0;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sst_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [sst_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sst_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [sst_pkg::M_TUSER_W-1:0]  m_tuser;

    held_entry_t held[$];
    tbl_result_t results_due[$];
    dir_row_t    dir_rows [N_ROWS];
    int          err_count   = 0;
    int          rx_count    = 0;
    int          idle_cycles = 0;
    bit          src_calm    = 1'b0;
    bit          sink_calm   = 1'b0;

    sorted_sequence_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic tbl_result_t outcome(logic [sst_pkg::STATUS_W-1:0] st, logic fnd,
                                            logic [sst_pkg::HANDLE_W-1:0] fh,
                                            logic [sst_pkg::CNT_W-1:0] rm,
                                            logic [sst_pkg::CNT_W-1:0] cnt,
                                            logic [sst_pkg::KEY_W-1:0] fk,
                                            logic [sst_pkg::KEY_W-1:0] lk,
                                            logic [sst_pkg::HANDLE_W-1:0] fhd,
                                            logic [sst_pkg::HANDLE_W-1:0] lhd);
        return '{st, fnd, fh, rm, cnt, fk, lk, fhd, lhd};
    endfunction

    // Apply one operation to the local copy of the table and return its result.
    function automatic tbl_result_t apply_table_op(logic [sst_pkg::MODE_W-1:0] mode,
                                                   logic [sst_pkg::KEY_W-1:0] key,
                                                   logic [sst_pkg::HANDLE_W-1:0] hnd,
                                                   logic ok);
        tbl_result_t r;
        int pos;
        r   = EMPTY_RESULT;
        pos = 0;
        case (mode)
            sst_pkg::MODE_INSERT: begin
                while (pos < held.size() && held[pos].key < key) pos++;
                if (!ok)
                    r.status = sst_pkg::STATUS_INVALID;
                else if (pos < held.size() && held[pos].key == key)
                    r.status = sst_pkg::STATUS_DUP;
                else if (held.size() >= sst_pkg::DEPTH)
                    r.status = sst_pkg::STATUS_FULL;
                else
                    held.insert(pos, '{key, hnd});
            end
            sst_pkg::MODE_LOOKUP: begin
                while (pos < held.size() && held[pos].key != key) pos++;
                if (pos < held.size()) begin
                    r.found        = 1'b1;
                    r.found_handle = held[pos].hnd;
                end
            end
            sst_pkg::MODE_TRIM_LO: begin
                while (held.size() > 0 && held[0].key < key) begin
                    held.delete(0);
                    r.removed++;
                end
            end
            sst_pkg::MODE_TRIM_HI: begin
                while (held.size() > 0 && key < held[held.size() - 1].key) begin
                    held.delete(held.size() - 1);
                    r.removed++;
                end
            end
            sst_pkg::MODE_CLEAR: begin
                r.removed = sst_pkg::CNT_W'(held.size());
                held.delete();
            end
            default: ;
        endcase
        r.count = sst_pkg::CNT_W'(held.size());
        if (held.size() > 0) begin
            r.first_key    = held[0].key;
            r.first_handle = held[0].hnd;
            r.last_key     = held[held.size() - 1].key;
            r.last_handle  = held[held.size() - 1].hnd;
        end
        return r;
    endfunction

    // Bias keys toward held ones and two narrow pools so duplicates and hits are common.
    function automatic logic [sst_pkg::KEY_W-1:0] pick_key();
        int unsigned r;
        logic [sst_pkg::KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 40 && held.size() > 0) begin
            k = held[$urandom_range(0, held.size() - 1)].key;
            case ($urandom_range(0, 2))
                0: k = k - 1;
                1: k = k + 1;
                default: ;
            endcase
        end else if (r < 80) begin
            k = ($urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FF80 : 64'h0)
                + sst_pkg::KEY_W'($urandom_range(0, 127));
        end else begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    task automatic report(string field, logic [sst_pkg::KEY_W-1:0] got,
                          logic [sst_pkg::KEY_W-1:0] want);
        if (err_count < 100)
            $display("MISMATCH result %0d %s: got %h, want %h", rx_count, field, got, want);
        err_count++;
    endtask

    task automatic check_result(tbl_result_t got);
        tbl_result_t want;
        if (results_due.size() == 0) begin
            report("unexpected transaction", 0, 0);
            return;
        end
        want = results_due[0];
        results_due.delete(0);
        if (got.status != want.status)       report("status", got.status, want.status);
        if (got.found != want.found)         report("found", got.found, want.found);
        if (got.found_handle != want.found_handle)
            report("found_handle", got.found_handle, want.found_handle);
        if (got.removed != want.removed)
            report("removed_count", got.removed, want.removed);
        if (got.count != want.count)         report("entry_count", got.count, want.count);
        if (got.first_key != want.first_key)
            report("first_key", got.first_key, want.first_key);
        if (got.last_key != want.last_key)   report("last_key", got.last_key, want.last_key);
        if (got.first_handle != want.first_handle)
            report("first_handle", got.first_handle, want.first_handle);
        if (got.last_handle != want.last_handle)
            report("last_handle", got.last_handle, want.last_handle);
    endtask

    task automatic send_op(logic [sst_pkg::MODE_W-1:0] mode, logic [sst_pkg::KEY_W-1:0] key,
                           logic [sst_pkg::HANDLE_W-1:0] hnd, logic ok, logic typed,
                           tbl_result_t want);
        tbl_result_t model;
        int gap;
        if ($urandom_range(0, 59) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, ok, hnd, key};
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        model = apply_table_op(mode, key, hnd, ok);
        results_due.insert(results_due.size(), typed ? want : model);
    endtask

    // Hold the sender off until every pending result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    initial begin
        dir_row_t row;
        int unsigned roll;
        int unsigned fill_pct;
        logic [sst_pkg::MODE_W-1:0] mode;
        fill_pct = 50;
        dir_rows = '{
            '{sst_pkg::MODE_LOOKUP,  64'h0,   16'h0000, 1'b1, 6'd1, 1'b1, EMPTY_RESULT},
            '{sst_pkg::MODE_TRIM_LO, KEY_TOP, 16'h0000, 1'b1, 6'd1, 1'b1, EMPTY_RESULT},
            '{sst_pkg::MODE_TRIM_HI, 64'h0,   16'h0000, 1'b1, 6'd1, 1'b1, EMPTY_RESULT},
            '{sst_pkg::MODE_CLEAR,   64'h0,   16'h0000, 1'b1, 6'd1, 1'b1, EMPTY_RESULT},
            '{MODE_SPARE_FIRST, KEY_TOP, 16'hFFFF, 1'b1, 6'd1, 1'b1, EMPTY_RESULT},
            '{sst_pkg::MODE_INSERT,  64'h0,   16'hFFFF, 1'b1, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_OK, 0, 0, 0, 1, 64'h0, 64'h0, 16'hFFFF, 16'hFFFF)},
            '{sst_pkg::MODE_INSERT,  KEY_TOP, 16'h0001, 1'b1, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_OK, 0, 0, 0, 2, 64'h0, KEY_TOP, 16'hFFFF, 16'h0001)},
            // handle not valid: table unchanged
            '{sst_pkg::MODE_INSERT,  64'h5,   16'h1234, 1'b0, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_INVALID, 0, 0, 0, 2, 64'h0, KEY_TOP, 16'hFFFF,
                      16'h0001)},
            '{sst_pkg::MODE_INSERT,  64'h0,   16'h4321, 1'b1, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_DUP, 0, 0, 0, 2, 64'h0, KEY_TOP, 16'hFFFF, 16'h0001)},
            '{sst_pkg::MODE_LOOKUP,  KEY_TOP, 16'h0000, 1'b1, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_OK, 1, 16'h0001, 0, 2, 64'h0, KEY_TOP, 16'hFFFF,
                      16'h0001)},
            '{sst_pkg::MODE_LOOKUP,  64'h7,   16'h0000, 1'b1, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_OK, 0, 0, 0, 2, 64'h0, KEY_TOP, 16'hFFFF, 16'h0001)},
            '{MODE_SPARE_LAST, 64'h0, 16'h0000, 1'b0, 6'd1, 1'b0, EMPTY_RESULT},
            // run of keys that fills the table, the last one bounces off it
            '{sst_pkg::MODE_INSERT,  RUN_BASE, 16'h0100, 1'b1, 6'd31, 1'b0, EMPTY_RESULT},
            '{sst_pkg::MODE_INSERT,  64'h10,   16'h2222, 1'b1, 6'd1, 1'b0, EMPTY_RESULT},
            // duplicate wins over full
            '{sst_pkg::MODE_INSERT,  KEY_TOP,  16'h3333, 1'b1, 6'd1, 1'b0, EMPTY_RESULT},
            '{sst_pkg::MODE_LOOKUP,  RUN_BASE + 64'h7,  16'h0000, 1'b1, 6'd1, 1'b0,
              EMPTY_RESULT},
            '{sst_pkg::MODE_TRIM_LO, RUN_BASE + 64'h3,  16'h0000, 1'b1, 6'd1, 1'b0,
              EMPTY_RESULT},
            '{sst_pkg::MODE_TRIM_HI, RUN_BASE + 64'h18, 16'h0000, 1'b1, 6'd1, 1'b0,
              EMPTY_RESULT},
            '{sst_pkg::MODE_TRIM_LO, RUN_BASE + 64'h3,  16'h0000, 1'b1, 6'd1, 1'b0,
              EMPTY_RESULT},
            '{sst_pkg::MODE_TRIM_HI, 64'h0,    16'h0000, 1'b1, 6'd1, 1'b0, EMPTY_RESULT},
            '{sst_pkg::MODE_INSERT,  64'h2A,   16'hAAAA, 1'b1, 6'd1, 1'b0, EMPTY_RESULT},
            '{sst_pkg::MODE_INSERT,  64'h15,   16'h5555, 1'b1, 6'd1, 1'b0, EMPTY_RESULT},
            '{sst_pkg::MODE_LOOKUP,  64'h15,   16'h0000, 1'b1, 6'd1, 1'b0, EMPTY_RESULT},
            '{sst_pkg::MODE_CLEAR,   64'h0,    16'h0000, 1'b1, 6'd1, 1'b1,
              outcome(sst_pkg::STATUS_OK, 0, 0, 2, 0, 64'h0, 64'h0, 16'h0, 16'h0)},
            '{sst_pkg::MODE_TRIM_LO, KEY_TOP,  16'h0000, 1'b1, 6'd1, 1'b1, EMPTY_RESULT}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int i = 0; i < row.reps; i++)
                send_op(row.mode, row.key + sst_pkg::KEY_W'(i),
                        row.hnd + sst_pkg::HANDLE_W'(i), row.ok, row.typed, row.want);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            // switch at random between fill-heavy and drain-heavy stretches
            if (n % 64 == 0) fill_pct = $urandom_range(0, 1) ? 85 : 40;
            if (n % 300 == 299) wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < fill_pct) begin
                mode = sst_pkg::MODE_INSERT;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 45)      mode = sst_pkg::MODE_LOOKUP;
                else if (roll < 70) mode = sst_pkg::MODE_TRIM_LO;
                else if (roll < 92) mode = sst_pkg::MODE_TRIM_HI;
                else if (roll < 97) mode = sst_pkg::MODE_CLEAR;
                else mode = sst_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST,
                                                             MODE_SPARE_LAST));
            end
            send_op(mode, pick_key(), sst_pkg::HANDLE_W'($urandom),
                    $urandom_range(0, 9) != 0, 1'b0, EMPTY_RESULT);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        tbl_result_t got;
        int gap;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 59) == 0) sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got.status       = m_tuser[1:0];
            got.found        = m_tuser[2];
            got.found_handle = m_tdata[15:0];
            got.removed      = m_tdata[21:16];
            got.count        = m_tdata[27:22];
            got.first_key    = m_tdata[91:28];
            got.last_key     = m_tdata[155:92];
            got.first_handle = m_tdata[171:156];
            got.last_handle  = m_tdata[187:172];
            check_result(got);
            rx_count++;
        end
    end

    // Abort when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* filelist.f */
sv/sst_pkg.sv
sv/sst_cell.sv
sv/sorted_sequence_table.sv
bench/sorted_sequence_table_tb.sv
